// ----- hw/rtl/tarhsp_pkg.sv -----
// shared constants and types for the tar header stream parser
package tarhsp_pkg;

    localparam int TAR_BLOCK_BYTES = 512;
    localparam int ACC_W           = 33;

    localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

    // octal field parse states
    localparam logic [1:0] OCT_SKIP   = 2'd0;
    localparam logic [1:0] OCT_DIGITS = 2'd1;
    localparam logic [1:0] OCT_DONE   = 2'd2;
    localparam logic [1:0] OCT_BAD    = 2'd3;

    // report status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_END     = 2'd1;
    localparam logic [1:0] STATUS_INVALID = 2'd2;
    localparam logic [1:0] STATUS_OCTAL   = 2'd3;

    // entry type codes
    localparam logic [1:0] TYPE_FILE    = 2'd0;
    localparam logic [1:0] TYPE_DIR     = 2'd1;
    localparam logic [1:0] TYPE_UNKNOWN = 2'd2;

    // result kinds
    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_DATA   = 1'b1;

    typedef struct packed {
        logic step;
        logic last;
        logic clear;
    } oct_ctrl_t;

endpackage

// ----- hw/rtl/tar_header_stream_parser.sv -----
// tar stream parser top level: header checks, reports, payload pass-through
// Takes one archive byte per beat and sustains one byte per clock cycle; a byte enters
// an input register and its result, if any, is then registered in the output register.
// The only thing that slows intake is back-pressure on the output register, since the
// single per-byte update step waits for a free output slot. Each 512-byte header yields
// one report beat on its last byte (status, size, mtime, type, padding); the entry's
// payload bytes then follow as data beats with tlast on the final one, and padding is
// consumed without output. After a report with a nonzero status, further bytes are
// accepted and dropped.
module tar_header_stream_parser
#(
    parameter int BLOCK_BYTES = tarhsp_pkg::TAR_BLOCK_BYTES
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // in_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // data_byte[7:0], status[9:8], entry_size[42:10], mod_time[75:43],
    // entry_type[77:76], pad_count[86:78], zero fill[87]
    output logic [87:0] m_axis_tdata,
    output logic        m_axis_tlast,  // last_data
    output logic        m_axis_tuser   // out_kind
);
    import tarhsp_pkg::*;

    localparam int POS_W = $clog2(BLOCK_BYTES);

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_DATA   = 2'd1;
    localparam logic [1:0] PH_PAD    = 2'd2;

    localparam logic [POS_W-1:0] POS_NAME_END  = POS_W'(100);
    localparam logic [POS_W-1:0] POS_MODE_NUL  = POS_W'(107);
    localparam logic [POS_W-1:0] POS_UID_NUL   = POS_W'(115);
    localparam logic [POS_W-1:0] POS_GID_NUL   = POS_W'(123);
    localparam logic [POS_W-1:0] POS_SIZE_LO   = POS_W'(124);
    localparam logic [POS_W-1:0] POS_SIZE_HI   = POS_W'(135);
    localparam logic [POS_W-1:0] POS_TIME_LO   = POS_W'(136);
    localparam logic [POS_W-1:0] POS_TIME_HI   = POS_W'(147);
    localparam logic [POS_W-1:0] POS_TYPE      = POS_W'(156);
    localparam logic [POS_W-1:0] POS_LINK_NUL  = POS_W'(256);
    localparam logic [POS_W-1:0] POS_LAST      = POS_W'(BLOCK_BYTES - 1);

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       fire;

    // parser state
    logic [1:0]       phase_reg, phase_next;
    logic [POS_W-1:0] byte_pos_reg, byte_pos_next;
    logic             name_ended_reg, name_ended_next;
    logic             header_bad_reg, header_bad_next;
    logic             first_zero_reg, first_zero_next;
    logic [1:0]       type_code_reg, type_code_next;
    logic [ACC_W-1:0] data_left_reg, data_left_next;
    logic [POS_W-1:0] pad_left_reg, pad_left_next;
    logic             stopped_reg, stopped_next;

    // octal field parsers
    oct_ctrl_t        size_ctrl, time_ctrl;
    logic [ACC_W-1:0] size_acc, time_acc;
    logic [1:0]       size_state, time_state;
    logic             header_start;

    // result
    logic             out_load;
    logic             out_kind;
    logic             out_last;
    logic [1:0]       out_status;
    logic [ACC_W-1:0] out_size;
    logic [ACC_W-1:0] out_time;
    logic [1:0]       out_type;
    logic [POS_W-1:0] out_pad;

    logic             out_valid_reg;
    logic             out_kind_reg;
    logic             out_last_reg;
    logic [7:0]       out_byte_reg;
    logic [1:0]       out_status_reg;
    logic [ACC_W-1:0] out_size_reg;
    logic [ACC_W-1:0] out_time_reg;
    logic [1:0]       out_type_reg;
    logic [POS_W-1:0] out_pad_reg;

    logic [ACC_W-1:0] data_dec;
    logic [POS_W-1:0] pad_dec;
    logic [POS_W-1:0] pad_val;
    logic [1:0]       status_val;
    logic             in_header;
    logic             b_zero;

    assign fire          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || fire;

    assign in_header = (phase_reg != PH_DATA) && (phase_reg != PH_PAD);
    assign b_zero    = (in_byte_reg == 8'h00);
    assign data_dec  = data_left_reg - ACC_W'(1);
    assign pad_dec   = pad_left_reg - POS_W'(1);
    // padding to the next block boundary
    assign pad_val   = POS_W'(0) - size_acc[POS_W-1:0];

    always_comb
    begin
        if (header_bad_reg)
            status_val = STATUS_INVALID;
        else if (first_zero_reg)
            status_val = STATUS_END;
        else if ((size_state == OCT_BAD) || (time_state == OCT_BAD))
            status_val = STATUS_OCTAL;
        else
            status_val = STATUS_OK;
    end

    always_comb
    begin
        size_ctrl.step  = fire && !stopped_reg && in_header &&
                          (byte_pos_reg >= POS_SIZE_LO) && (byte_pos_reg <= POS_SIZE_HI);
        size_ctrl.last  = (byte_pos_reg == POS_SIZE_HI);
        size_ctrl.clear = header_start;
        time_ctrl.step  = fire && !stopped_reg && in_header &&
                          (byte_pos_reg >= POS_TIME_LO) && (byte_pos_reg <= POS_TIME_HI);
        time_ctrl.last  = (byte_pos_reg == POS_TIME_HI);
        time_ctrl.clear = header_start;
    end

    tarhsp_octal_field u_size_field
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (size_ctrl),
        .byte_in (in_byte_reg),
        .acc     (size_acc),
        .state   (size_state)
    );

    tarhsp_octal_field u_time_field
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (time_ctrl),
        .byte_in (in_byte_reg),
        .acc     (time_acc),
        .state   (time_state)
    );

    always_comb
    begin
        phase_next      = phase_reg;
        byte_pos_next   = byte_pos_reg;
        name_ended_next = name_ended_reg;
        header_bad_next = header_bad_reg;
        first_zero_next = first_zero_reg;
        type_code_next  = type_code_reg;
        data_left_next  = data_left_reg;
        pad_left_next   = pad_left_reg;
        stopped_next    = stopped_reg;
        header_start    = 1'b0;
        out_load        = 1'b0;
        out_kind        = KIND_REPORT;
        out_last        = 1'b0;
        out_status      = STATUS_OK;
        out_size        = '0;
        out_time        = '0;
        out_type        = TYPE_FILE;
        out_pad         = '0;

        if (fire && !stopped_reg)
        begin
            case (phase_reg)
                PH_DATA:
                begin
                    data_left_next = data_dec;
                    out_load       = 1'b1;
                    out_kind       = KIND_DATA;
                    out_last       = (data_dec == '0);
                    if (data_dec == '0)
                    begin
                        if (pad_left_reg != '0)
                            phase_next = PH_PAD;
                        else
                            header_start = 1'b1;
                    end
                end
                PH_PAD:
                begin
                    pad_left_next = pad_dec;
                    if (pad_dec == '0)
                        header_start = 1'b1;
                end
                default:
                begin
                    if (byte_pos_reg < POS_NAME_END)
                    begin
                        if (b_zero)
                            name_ended_next = 1'b1;
                        else if (name_ended_reg)
                            header_bad_next = 1'b1;
                        if (byte_pos_reg == '0)
                            first_zero_next = b_zero;
                    end
                    if (((byte_pos_reg == POS_MODE_NUL) || (byte_pos_reg == POS_UID_NUL) ||
                         (byte_pos_reg == POS_GID_NUL) || (byte_pos_reg == POS_LINK_NUL)) &&
                        !b_zero)
                        header_bad_next = 1'b1;
                    if (((byte_pos_reg == POS_SIZE_HI) || (byte_pos_reg == POS_TIME_HI)) &&
                        !b_zero && (in_byte_reg != 8'h20))
                        header_bad_next = 1'b1;
                    if (byte_pos_reg == POS_TYPE)
                    begin
                        if (b_zero || (in_byte_reg == 8'h30))
                            type_code_next = TYPE_FILE;
                        else if (in_byte_reg == 8'h35)
                            type_code_next = TYPE_DIR;
                        else
                            type_code_next = TYPE_UNKNOWN;
                    end

                    if (byte_pos_reg != POS_LAST)
                    begin
                        byte_pos_next = byte_pos_reg + POS_W'(1);
                    end
                    else
                    begin
                        // checks all lie before the last byte, so the held flags are final
                        out_load   = 1'b1;
                        out_status = status_val;
                        if (status_val != STATUS_OK)
                        begin
                            stopped_next = 1'b1;
                        end
                        else
                        begin
                            out_size     = size_acc;
                            out_time     = time_acc;
                            out_type     = type_code_reg;
                            out_pad      = pad_val;
                            header_start = 1'b1;
                            if (size_acc != '0)
                            begin
                                data_left_next = size_acc;
                                pad_left_next  = pad_val;
                            end
                        end
                    end
                end
            endcase
        end

        if (header_start)
        begin
            phase_next      = PH_HEADER;
            byte_pos_next   = '0;
            name_ended_next = 1'b0;
            header_bad_next = 1'b0;
            first_zero_next = 1'b0;
            type_code_next  = TYPE_FILE;
            // a good header with data goes straight to the payload
            if (in_header && (size_acc != '0))
                phase_next = PH_DATA;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            phase_reg      <= PH_HEADER;
            byte_pos_reg   <= '0;
            name_ended_reg <= 1'b0;
            header_bad_reg <= 1'b0;
            first_zero_reg <= 1'b0;
            type_code_reg  <= TYPE_FILE;
            data_left_reg  <= '0;
            pad_left_reg   <= '0;
            stopped_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            phase_reg      <= phase_next;
            byte_pos_reg   <= byte_pos_next;
            name_ended_reg <= name_ended_next;
            header_bad_reg <= header_bad_next;
            first_zero_reg <= first_zero_next;
            type_code_reg  <= type_code_next;
            data_left_reg  <= data_left_next;
            pad_left_reg   <= pad_left_next;
            stopped_reg    <= stopped_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
            in_byte_reg <= s_axis_tdata;
        if (out_load)
        begin
            out_kind_reg   <= out_kind;
            out_last_reg   <= out_last;
            out_byte_reg   <= (out_kind == KIND_DATA) ? in_byte_reg : 8'h00;
            out_status_reg <= out_status;
            out_size_reg   <= out_size;
            out_time_reg   <= out_time;
            out_type_reg   <= out_type;
            out_pad_reg    <= out_pad;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {1'b0, out_pad_reg, out_type_reg, out_time_reg, out_size_reg,
                            out_status_reg, out_byte_reg};

`ifndef SYNTHESIS
    a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        stopped_reg |=> stopped_reg)
        else $error("stop flag cleared");

    a_data_left_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA) |-> (data_left_reg != '0))
        else $error("data phase with nothing left");

    a_pad_left_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAD) |-> (pad_left_reg != '0))
        else $error("pad phase with nothing left");

    a_no_result_when_stopped: assert property (@(posedge clk) disable iff (!rst_n)
        stopped_reg |-> !out_load)
        else $error("result after stop");

    a_data_beat_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_kind_reg == KIND_DATA)) |->
        ((out_status_reg == STATUS_OK) && (out_size_reg == '0)))
        else $error("data beat carries report fields");
`endif

endmodule

// ----- hw/rtl/tarhsp_octal_field.sv -----
// octal number field parser with whitespace skip and saturation
module tarhsp_octal_field
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  tarhsp_pkg::oct_ctrl_t         ctrl,
    input  logic [7:0]                    byte_in,
    output logic [tarhsp_pkg::ACC_W-1:0]  acc,
    output logic [1:0]                    state
);
    import tarhsp_pkg::*;

    logic [ACC_W-1:0] acc_reg;
    logic [ACC_W-1:0] acc_next;
    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic             is_digit;
    logic             is_ws;
    logic [ACC_W-1:0] digit_val;

    assign is_digit  = (byte_in >= 8'h30) && (byte_in <= 8'h37);
    assign is_ws     = (byte_in == 8'h20) || ((byte_in >= 8'h09) && (byte_in <= 8'h0d));
    assign digit_val = {{(ACC_W-3){1'b0}}, byte_in[2:0]};

    always_comb
    begin
        acc_next   = acc_reg;
        state_next = state_reg;
        if (ctrl.clear)
        begin
            acc_next   = '0;
            state_next = OCT_SKIP;
        end
        else if (ctrl.step)
        begin
            case (state_reg)
                OCT_SKIP:
                begin
                    if (is_digit)
                    begin
                        acc_next   = digit_val;
                        state_next = OCT_DIGITS;
                    end
                    else if (!is_ws || ctrl.last)
                    begin
                        state_next = OCT_BAD;
                    end
                end
                OCT_DIGITS:
                begin
                    if (is_digit)
                    begin
                        // saturate rather than wrap
                        if (acc_reg > (ACC_MAX >> 3))
                            acc_next = ACC_MAX;
                        else
                            acc_next = {acc_reg[ACC_W-4:0], byte_in[2:0]};
                    end
                    else
                    begin
                        state_next = OCT_DONE;
                    end
                end
                default:
                begin
                    state_next = state_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            state_reg <= OCT_SKIP;
        end
        else
        begin
            acc_reg   <= acc_next;
            state_reg <= state_next;
        end
    end

    assign acc   = acc_reg;
    assign state = state_reg;

endmodule

// ----- verif/testbench.sv -----
// self-checking testbench for the tar header stream parser
`timescale 1ns / 100ps

module testbench;
    import tarhsp_pkg::*;

    localparam int CYCLE_LIMIT = 4_000_000;

    typedef enum logic [1:0] {WALK_HEADER, WALK_DATA, WALK_PAD} walk_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data;
        logic        last;
        logic [1:0]  status;
        logic [32:0] size;
        logic [32:0] mtime;
        logic [1:0]  etype;
        logic [8:0]  pad;
    } tar_beat_t;

    // mirrors the archive walk and keeps the beats the block owes us
    class tar_scoreboard;
        walk_t       walk;
        int          byte_pos;
        bit          name_ended;
        bit          header_bad;
        bit          first_zero;
        logic [32:0] size_acc;
        logic [1:0]  size_st;
        logic [32:0] time_acc;
        logic [1:0]  time_st;
        logic [1:0]  type_code;
        logic [32:0] data_left;
        logic [8:0]  pad_left;
        bit          stopped;
        tar_beat_t   owed_q[$];
        int          fail_count;

        function new();
            start_header();
            data_left  = '0;
            pad_left   = '0;
            stopped    = 1'b0;
            fail_count = 0;
        endfunction

        function void start_header();
            walk       = WALK_HEADER;
            byte_pos   = 0;
            name_ended = 1'b0;
            header_bad = 1'b0;
            first_zero = 1'b0;
            size_acc   = '0;
            size_st    = OCT_SKIP;
            time_acc   = '0;
            time_st    = OCT_SKIP;
            type_code  = TYPE_FILE;
        endfunction

        function bit is_space(logic [7:0] b);
            return b == 8'h20 || (b >= 8'd9 && b <= 8'd13);
        endfunction

        function void octal_byte(inout logic [32:0] acc, inout logic [1:0] st,
                                 input logic [7:0] b, input bit field_end);
            bit digit;
            digit = (b >= "0" && b <= "7");
            case (st)
                OCT_SKIP:
                begin
                    if (digit)
                    begin
                        acc = {30'd0, b[2:0]};
                        st  = OCT_DIGITS;
                    end
                    else if (!is_space(b) || field_end)
                        st = OCT_BAD;
                end
                OCT_DIGITS:
                begin
                    if (!digit)
                        st = OCT_DONE;
                    else if (acc > (ACC_MAX >> 3))
                        acc = ACC_MAX;
                    else
                        acc = {acc[29:0], b[2:0]};
                end
                default: ;
            endcase
        endfunction

        function void note_byte(logic [7:0] b);
            tar_beat_t   res;
            logic [1:0]  st;
            logic [32:0] sz;
            res = '0;
            if (stopped)
                return;
            case (walk)
                WALK_DATA:
                begin
                    data_left = data_left - 33'd1;
                    res.kind  = KIND_DATA;
                    res.data  = b;
                    res.last  = (data_left == 0);
                    owed_q.push_back(res);
                    if (data_left == 0)
                    begin
                        if (pad_left != 0)
                            walk = WALK_PAD;
                        else
                            start_header();
                    end
                end
                WALK_PAD:
                begin
                    pad_left = pad_left - 9'd1;
                    if (pad_left == 0)
                        start_header();
                end
                default:
                begin
                    if (byte_pos < 100)
                    begin
                        if (b == 0)
                            name_ended = 1'b1;
                        else if (name_ended)
                            header_bad = 1'b1;
                        if (byte_pos == 0)
                            first_zero = (b == 0);
                    end
                    if ((byte_pos == 107 || byte_pos == 115 || byte_pos == 123 ||
                         byte_pos == 256) && b != 0)
                        header_bad = 1'b1;
                    if ((byte_pos == 135 || byte_pos == 147) && b != 0 && b != 8'h20)
                        header_bad = 1'b1;
                    if (byte_pos >= 124 && byte_pos <= 135)
                        octal_byte(size_acc, size_st, b, byte_pos == 135);
                    if (byte_pos >= 136 && byte_pos <= 147)
                        octal_byte(time_acc, time_st, b, byte_pos == 147);
                    if (byte_pos == 156)
                        type_code = (b == 0 || b == "0") ? TYPE_FILE :
                                    (b == "5") ? TYPE_DIR : TYPE_UNKNOWN;
                    if (byte_pos < TAR_BLOCK_BYTES - 1)
                        byte_pos++;
                    else
                    begin
                        res.kind = KIND_REPORT;
                        if (header_bad)
                            st = STATUS_INVALID;
                        else if (first_zero)
                            st = STATUS_END;
                        else if (size_st == OCT_BAD || time_st == OCT_BAD)
                            st = STATUS_OCTAL;
                        else
                            st = STATUS_OK;
                        res.status = st;
                        if (st != STATUS_OK)
                            stopped = 1'b1;
                        else
                        begin
                            sz        = size_acc;
                            res.size  = sz;
                            res.mtime = time_acc;
                            res.etype = type_code;
                            res.pad   = 9'(10'd512 - {1'b0, sz[8:0]});
                            start_header();
                            if (sz != 0)
                            begin
                                walk      = WALK_DATA;
                                data_left = sz;
                                pad_left  = res.pad;
                            end
                        end
                        owed_q.push_back(res);
                    end
                end
            endcase
        endfunction

        function void compare(string name, logic [32:0] want, logic [32:0] got);
            if (got !== want)
            begin
                $error("%s mismatch: expected %0h, got %0h", name, want, got);
                fail_count++;
            end
        endfunction

        function void check_beat(logic kind, logic [87:0] word, logic last);
            tar_beat_t want;
            if (owed_q.size() == 0)
            begin
                $error("output beat with nothing owed: tuser %0h tdata %0h", kind, word);
                fail_count++;
                return;
            end
            want = owed_q.pop_front();
            compare("out_kind", 33'(want.kind), 33'(kind));
            compare("data_byte", 33'(want.data), 33'(word[7:0]));
            compare("last_data", 33'(want.last), 33'(last));
            compare("status", 33'(want.status), 33'(word[9:8]));
            compare("entry_size", want.size, word[42:10]);
            compare("mod_time", want.mtime, word[75:43]);
            compare("entry_type", 33'(want.etype), 33'(word[77:76]));
            compare("pad_count", 33'(want.pad), 33'(word[86:78]));
            compare("zero fill", 33'd0, 33'(word[87]));
        endfunction

        function int pending();
            return owed_q.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // in_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // data_byte, status, entry_size, mod_time, entry_type, pad_count, zero fill
    logic [87:0] m_axis_tdata;
    logic        m_axis_tlast;   // last_data
    logic        m_axis_tuser;   // out_kind

    tar_scoreboard sb = new();
    logic [7:0]    hdr_buf [0:511];
    bit            tx_idle;
    bit            rx_idle;
    int            rx_hold_len;
    int            rx_stall_left;
    int            cycle_count;

    tar_header_stream_parser i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_byte(s_axis_tdata);
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_beat(m_axis_tuser, m_axis_tdata, m_axis_tlast);
    end

    function automatic int gap_len(bit enabled);
        int r;
        r = $urandom_range(0, 99);
        if (!enabled || r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 24);
    endfunction

    // receiver: long hold-off on request, otherwise random stalls
    initial
    begin
        m_axis_tready = 1'b0;
        rx_hold_len   = 0;
        rx_stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_len > 0)
            begin
                m_axis_tready <= 1'b0;
                rx_hold_len--;
            end
            else if (rx_stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                rx_stall_left--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                rx_stall_left = gap_len(rx_idle);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = gap_len(tx_idle);
        if (gap > 0)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] ws_char();
        int r;
        r = $urandom_range(8, 13);
        return (r == 8) ? 8'h20 : 8'(r);
    endfunction

    function automatic logic [7:0] non_digit();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b >= "0" && b <= "7");
        return b;
    endfunction

    function automatic int octal_digits(logic [32:0] v);
        int n;
        n = 1;
        while (v > 7)
        begin
            v = v >> 3;
            n++;
        end
        return n;
    endfunction

    // octal field of 12 bytes at base: whitespace, digits, terminator, free bytes, space or NUL last
    function automatic void put_octal(int base, logic [32:0] value);
        int nd;
        int ws;
        int zeros;
        int p;
        nd    = octal_digits(value);
        ws    = $urandom_range(0, 11 - nd);
        zeros = $urandom_range(0, 11 - nd - ws);
        p     = base;
        repeat (ws)
        begin
            hdr_buf[p] = ws_char();
            p++;
        end
        for (int i = nd + zeros - 1; i >= 0; i--)
        begin
            hdr_buf[p] = 8'h30 + 8'((value >> (3 * i)) & 33'd7);
            p++;
        end
        if (p <= base + 10)
            hdr_buf[p] = non_digit();
        hdr_buf[base + 11] = $urandom_range(0, 1) ? 8'h20 : 8'h00;
    endfunction

    function automatic void build_header(int name_len, logic [32:0] size,
                                         logic [32:0] mtime, logic [7:0] type_byte);
        for (int i = 0; i < 512; i++)
            hdr_buf[i] = 8'($urandom_range(0, 255));
        for (int i = 0; i < 100; i++)
            hdr_buf[i] = (i < name_len) ? 8'($urandom_range(1, 255)) : 8'h00;
        hdr_buf[107] = 8'h00;
        hdr_buf[115] = 8'h00;
        hdr_buf[123] = 8'h00;
        hdr_buf[256] = 8'h00;
        put_octal(124, size);
        put_octal(136, mtime);
        hdr_buf[156] = type_byte;
    endfunction

    // header from the buffer, then payload and padding
    task automatic transmit_entry(int size);
        for (int i = 0; i < 512; i++)
            send_byte(hdr_buf[i]);
        for (int i = 0; i < size; i++)
            send_byte(8'($urandom_range(0, 255)));
        for (int i = 0; i < (512 - size % 512) % 512; i++)
            send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic send_entry(int name_len, int size, logic [32:0] mtime,
                              logic [7:0] type_byte);
        build_header(name_len, 33'(size), mtime, type_byte);
        transmit_entry(size);
    endtask

    function automatic logic [32:0] rand_mtime();
        return {1'($urandom_range(0, 1)), 32'($urandom)};
    endfunction

    function automatic logic [7:0] rand_type();
        case ($urandom_range(0, 3))
            0: return 8'h00;
            1: return "0";
            2: return "5";
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // one header that stops the block: end of archive, invalid, or bad octal
    task automatic send_stopper();
        int base;
        int pos;
        build_header($urandom_range(1, 100), 33'($urandom_range(0, 40)), rand_mtime(),
                     rand_type());
        base = $urandom_range(0, 1) ? 124 : 136;
        case ($urandom_range(0, 2))
            0:
            begin
                for (int i = 0; i < 100; i++)
                    hdr_buf[i] = 8'h00;
                // end of archive wins over a broken octal field
                if ($urandom_range(0, 1))
                    hdr_buf[base] = "-";
            end
            1:
            begin
                case ($urandom_range(0, 5))
                    0:
                    begin
                        pos = $urandom_range(0, 98);
                        hdr_buf[pos] = 8'h00;
                        hdr_buf[$urandom_range(pos + 1, 99)] = 8'($urandom_range(1, 255));
                    end
                    1: hdr_buf[107] = 8'($urandom_range(1, 255));
                    2: hdr_buf[115] = 8'($urandom_range(1, 255));
                    3: hdr_buf[123] = 8'($urandom_range(1, 255));
                    4: hdr_buf[256] = 8'($urandom_range(1, 255));
                    default: hdr_buf[base + 11] = 8'($urandom_range(33, 255));
                endcase
                // invalid wins over end of archive and bad octal
                if ($urandom_range(0, 1))
                    hdr_buf[0] = 8'h00;
                if ($urandom_range(0, 1))
                    hdr_buf[base] = "+";
            end
            default:
            begin
                case ($urandom_range(0, 3))
                    0: hdr_buf[base] = $urandom_range(0, 1) ? "+" : "-";
                    1: hdr_buf[base] = 8'h00;
                    2: hdr_buf[base] = 8'($urandom_range(65, 90));
                    default:
                    begin
                        for (int i = 0; i < 11; i++)
                            hdr_buf[base + i] = ws_char();
                        hdr_buf[base + 11] = 8'h20;
                    end
                endcase
            end
        endcase
        transmit_entry(0);
        // everything after this is accepted and dropped
        repeat (16)
            send_byte(8'($urandom_range(0, 255)));
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        tx_idle       = 1'b0;
        rx_idle       = 1'b0;
        cycle_count   = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // receiver holds off while the sender keeps going, full-length name and top mtime
        rx_idle     = 1'b1;
        rx_hold_len = 1200;
        send_entry(100, $urandom_range(1, 511), ACC_MAX, rand_type());
        wait_drained();

        tx_idle = 1'b1;
        send_stopper();

        wait_drained();
        repeat (16) @(posedge clk);
        if (sb.fail_count == 0 && sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/tarhsp_pkg.sv
hw/rtl/tarhsp_octal_field.sv
hw/rtl/tar_header_stream_parser.sv
verif/testbench.sv
